FILE: rtl/sobel_edge_threshold_macros.svh
// Assertion macros shared by the Sobel edge magnitude RTL.
`ifndef SOBEL_EDGE_THRESHOLD_MACROS_SVH
`define SOBEL_EDGE_THRESHOLD_MACROS_SVH

// Check that cons holds in the same cycle as ante (needs clk and arst_n in scope).
`define SOBET_CHECK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that cons holds in the cycle after ante.
`define SOBET_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/sobet_pkg.sv
// Shared types and constants of the Sobel edge magnitude block.
`timescale 1ns / 1ps

package sobet_pkg;

	// Configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

	// Register widths and reset values
	localparam int FW_W  = 11;
	localparam int FH_W  = 16;
	localparam int THR_W = 11;

	localparam logic [FW_W-1:0]  FRAME_WIDTH_RST    = 11'd640;
	localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST   = 16'd480;
	localparam logic [THR_W-1:0] EDGE_THRESHOLD_RST = 11'd128;

	// Stream fields
	localparam int GREY_W    = 8;
	localparam int MAG_W     = 11;
	localparam int M_TDATA_W = 24;
	localparam int ROW_W     = FH_W + 1;

	localparam logic [MAG_W-1:0] MAG_MAX = 11'd2047;

	// Input command codes
	localparam logic CMD_PIXEL = 1'b0;

	// Window control for one item
	typedef struct packed {
		logic update;     // apply the new column to the window
		logic load;       // fill all three columns (first pixel of a row)
		logic grad;       // compute a gradient for this item
		logic center_sel; // right column comes from the old window
	} win_ctl_t;

endpackage

FILE: rtl/sobet_linebuf.sv
// Line store: synchronous RAM holding the upper and middle rows per column.
`timescale 1ns / 1ps

module sobet_linebuf #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [0:DEPTH-1];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/sobet_window.sv
// 3x3 pixel window, Sobel gradients and the squared-sum pipeline.
`timescale 1ns / 1ps

module sobet_window #(
	parameter int PIXEL_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sobet_pkg::win_ctl_t       ctl,
	input  logic [PIXEL_BITS-1:0]     col_top,
	input  logic [PIXEL_BITS-1:0]     col_mid,
	input  logic [PIXEL_BITS-1:0]     col_bot,
	output logic                      sum_valid,
	output logic [2*PIXEL_BITS+4:0]   sum_sq
);

	localparam int PS_W  = PIXEL_BITS + 2;
	localparam int GW    = PIXEL_BITS + 3;
	localparam int SQ_W  = 2 * PIXEL_BITS + 4;
	localparam int SUM_W = SQ_W + 1;

	// win_q[column][row]: column 0 left, row 0 top
	logic [PIXEL_BITS-1:0] win_q [0:2][0:2];

	logic [PIXEL_BITS-1:0] r_top, r_mid, r_bot;
	logic [PS_W-1:0]       sx_left, sx_right, sy_top, sy_bot;
	logic signed [GW-1:0]  gx, gy;
	logic signed [GW-1:0]  gx_s1, gy_s1;
	logic                  grad_v_s1;
	logic signed [2*GW-1:0] prod_x, prod_y;
	logic [SQ_W-1:0]       sq_x_s2, sq_y_s2;
	logic                  sq_v_s2;
	logic [SUM_W-1:0]      sum_s3;
	logic                  sum_v_s3;

	// Load at row start, otherwise shift left and append the new column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 3; r++) begin
					win_q[c][r] <= '0;
				end
			end
		end else if (ctl.update) begin
			if (ctl.load) begin
				for (int c = 0; c < 3; c++) begin
					win_q[c][0] <= col_top;
					win_q[c][1] <= col_mid;
					win_q[c][2] <= col_bot;
				end
			end else begin
				for (int r = 0; r < 3; r++) begin
					win_q[0][r] <= win_q[1][r];
					win_q[1][r] <= win_q[2][r];
				end
				win_q[2][0] <= col_top;
				win_q[2][1] <= col_mid;
				win_q[2][2] <= col_bot;
			end
		end
	end

	// Left and center columns are old columns 1 and 2; right repeats the
	// center at row start and frame end, else it is the incoming column
	always_comb begin
		r_top = ctl.center_sel ? win_q[2][0] : col_top;
		r_mid = ctl.center_sel ? win_q[2][1] : col_mid;
		r_bot = ctl.center_sel ? win_q[2][2] : col_bot;

		sx_left  = PS_W'(win_q[1][0]) + {1'b0, win_q[1][1], 1'b0} + PS_W'(win_q[1][2]);
		sx_right = PS_W'(r_top) + {1'b0, r_mid, 1'b0} + PS_W'(r_bot);
		sy_top   = PS_W'(win_q[1][0]) + {1'b0, win_q[2][0], 1'b0} + PS_W'(r_top);
		sy_bot   = PS_W'(win_q[1][2]) + {1'b0, win_q[2][2], 1'b0} + PS_W'(r_bot);

		gx = $signed({1'b0, sx_left}) - $signed({1'b0, sx_right});
		gy = $signed({1'b0, sy_top}) - $signed({1'b0, sy_bot});
	end

	assign prod_x = gx_s1 * gx_s1;
	assign prod_y = gy_s1 * gy_s1;

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grad_v_s1 <= 1'b0;
			sq_v_s2   <= 1'b0;
			sum_v_s3  <= 1'b0;
		end else begin
			grad_v_s1 <= ctl.grad;
			sq_v_s2   <= grad_v_s1;
			sum_v_s3  <= sq_v_s2;
		end
	end

	// Gradient, square and sum stages
	always_ff @(posedge clk) begin
		if (ctl.grad) begin
			gx_s1 <= gx;
			gy_s1 <= gy;
		end
		if (grad_v_s1) begin
			sq_x_s2 <= prod_x[SQ_W-1:0];
			sq_y_s2 <= prod_y[SQ_W-1:0];
		end
		if (sq_v_s2) begin
			sum_s3 <= SUM_W'(sq_x_s2) + SUM_W'(sq_y_s2);
		end
	end

	assign sum_valid = sum_v_s3;
	assign sum_sq    = sum_s3;

endmodule

FILE: rtl/sobet_isqrt.sv
// Bit-serial integer square root, one root bit per cycle.
`timescale 1ns / 1ps
`include "sobel_edge_threshold_macros.svh"

module sobet_isqrt #(
	parameter int ROOT_W = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [2*ROOT_W-1:0]   value,
	output logic                  done,
	output logic [ROOT_W-1:0]     root
);

	localparam int CNT_W = $clog2(ROOT_W);
	localparam int REM_W = ROOT_W + 2;

	logic                busy_q, done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [2*ROOT_W-1:0] val_q;
	logic [REM_W-1:0]    rem_q;
	logic [ROOT_W-1:0]   root_q;

	logic [REM_W-1:0]    rem_sh, trial, rem_nx;
	logic                fits;
	logic [ROOT_W-1:0]   root_nx;

	// Bring down two bits and try the next root bit
	always_comb begin
		rem_sh  = {rem_q[ROOT_W-1:0], val_q[2*ROOT_W-1 -: 2]};
		trial   = {root_q, 2'b01};
		fits    = rem_sh >= trial;
		rem_nx  = fits ? (rem_sh - trial) : rem_sh;
		root_nx = {root_q[ROOT_W-2:0], fits};
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Operand, remainder and partial root
	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= val_q << 2;
			rem_q  <= rem_nx;
			root_q <= root_nx;
		end
	end

	assign done = done_q;
	assign root = root_q;

	`SOBET_CHECK_NOW(a_start_idle, start, !busy_q, "square root restarted while busy")

endmodule

FILE: rtl/sobel_edge_threshold.sv
// Sobel 3x3 edge magnitude with threshold over a raster pixel stream.
`timescale 1ns / 1ps
`include "sobel_edge_threshold_macros.svh"

// Sobel edge magnitude: grey pixels enter in raster order on the slave stream
// (s_tuser low); each result is floor(sqrt(gx^2 + gy^2)) of the clamped 3x3
// neighborhood of one pixel, plus that value zeroed below edge_threshold.
// Results trail the input by one row plus one pixel; after the last pixel of
// a frame send frame_width + 1 drain transactions (s_tuser high) to flush the
// last row. Pixels sent while drains are due, and drains sent before the frame
// ends, are dropped without a result. Items are handled one at a time: a
// dropped item ends on acceptance, one without a result after the line store
// read-modify-write, and one with a result passes the gradient, square and
// sum stages and the square root unit, which resolves one root bit per cycle,
// on to the result register. The next item is accepted while a result waits
// on m_tready. The two line stores share one RAM, read on acceptance and
// written back in the cycle after it; they need no clearing after reset.
// Write the registers only while no item is in flight.
module sobel_edge_threshold #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input pixel stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [sobet_pkg::GREY_W-1:0]       s_tdata,   // [7:0] grey
	input  logic                               s_tuser,   // [0] command
	// Result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [sobet_pkg::M_TDATA_W-1:0]    m_tdata,   // [10:0] magnitude,
	                                                      // [21:11] edge_value,
	                                                      // [22] is_edge
	output logic                               m_tlast,   // end_of_row
	output logic                               m_tuser,   // [0] end_of_frame
	// Configuration writes
	input  logic                               cfg_we,
	input  logic [sobet_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [sobet_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = PIXEL_BITS + 3;
	localparam int SUM_W = 2 * PIXEL_BITS + 5;
	localparam int ROW_W = sobet_pkg::ROW_W;
	localparam int MAG_W = sobet_pkg::MAG_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_ROOT = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	// Configuration registers
	logic [sobet_pkg::FW_W-1:0]  frame_width_q;
	logic [sobet_pkg::FH_W-1:0]  frame_height_q;
	logic [sobet_pkg::THR_W-1:0] edge_threshold_q;

	// Frame position
	logic [CW-1:0]    in_col_q, out_col_q;
	logic [ROW_W-1:0] in_row_q, out_row_q;

	logic [1:0] state_q;

	// Item under work
	logic [CW-1:0]         item_col_q;
	logic [PIXEL_BITS-1:0] item_pix_q;
	logic                  item_feed_q, item_row0_q, item_col0_q;
	logic                  item_emit_q, item_last_q, item_eor_q, item_eof_q;

	// Result register
	logic             m_tvalid_q;
	logic [MAG_W-1:0] mag_q, edge_q;
	logic             is_edge_q, eor_q, eof_q;

	// Acceptance-time decode
	logic [WW-1:0]                w_eff;
	logic [sobet_pkg::FH_W-1:0]   h_eff;
	logic [ROW_W-1:0]             hp1;
	logic                         restart;
	logic [CW-1:0]                col_e, ocol_e;
	logic [ROW_W-1:0]             row_e, orow_e;
	logic                         feeding, is_pixel, item_skip, emit, last_phase;
	logic                         eor, eof;
	logic [31:0]                  icol_inc, ocol_inc;
	logic [ROW_W-1:0]             orow_inc;
	logic [PIXEL_BITS+sobet_pkg::GREY_W-1:0] grey_ext;
	logic [PIXEL_BITS-1:0]        pix_in;
	logic                         s_acc;

	// Line store, window and root
	logic [2*PIXEL_BITS-1:0] lb_rd_data, lb_wr_data;
	logic                    lb_wr_en;
	logic [PIXEL_BITS-1:0]   px_top, px_mid, px_bot;
	sobet_pkg::win_ctl_t     win_ctl;
	logic                    sum_valid;
	logic [SUM_W-1:0]        sum_sq;
	logic                    root_done;
	logic [RW-1:0]           root;
	logic [MAG_W-1:0]        mag_sat, edge_nx;
	logic                    out_free, load_out;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= sobet_pkg::FRAME_WIDTH_RST;
			frame_height_q   <= sobet_pkg::FRAME_HEIGHT_RST;
			edge_threshold_q <= sobet_pkg::EDGE_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sobet_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data[sobet_pkg::FW_W-1:0];
				end
				sobet_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data[sobet_pkg::FH_W-1:0];
				end
				sobet_pkg::REG_EDGE_THRESHOLD: begin
					edge_threshold_q <= cfg_data[sobet_pkg::THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Clamp frame size, restart on out-of-frame counters, classify the item
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(frame_width_q);
		end
		h_eff = (frame_height_q == '0) ? sobet_pkg::FH_W'(1) : frame_height_q;
		hp1   = ROW_W'(h_eff) + ROW_W'(1);

		restart = (32'(in_col_q) >= 32'(w_eff)) || (in_row_q > hp1)
			|| ((in_row_q == hp1) && (in_col_q != '0));
		col_e  = restart ? '0 : in_col_q;
		row_e  = restart ? '0 : in_row_q;
		ocol_e = restart ? '0 : out_col_q;
		orow_e = restart ? '0 : out_row_q;

		feeding    = row_e < ROW_W'(h_eff);
		is_pixel   = (s_tuser == sobet_pkg::CMD_PIXEL);
		item_skip  = (feeding != is_pixel);
		emit       = (row_e >= ROW_W'(2)) || ((row_e == ROW_W'(1)) && (col_e != '0));
		last_phase = (row_e == hp1);

		eor = (32'(ocol_e) + 32'd1) >= 32'(w_eff);
		eof = eor && ((32'(orow_e) + 32'd1) >= 32'(h_eff));

		icol_inc = 32'(col_e) + 32'd1;
		ocol_inc = 32'(ocol_e) + 32'd1;
		orow_inc = (&orow_e) ? orow_e : orow_e + ROW_W'(1);

		grey_ext = (PIXEL_BITS + sobet_pkg::GREY_W)'(s_tdata);
		pix_in   = grey_ext[PIXEL_BITS-1:0];
	end

	// Advance frame counters on each accepted item that is not dropped; a dropped one only applies a restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (s_acc) begin
			if (item_skip) begin
				in_col_q  <= col_e;
				in_row_q  <= row_e;
				out_col_q <= ocol_e;
				out_row_q <= orow_e;
			end else if (last_phase) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (icol_inc >= 32'(w_eff)) begin
					in_col_q <= '0;
					in_row_q <= row_e + ROW_W'(1);
				end else begin
					in_col_q <= CW'(icol_inc);
					in_row_q <= row_e;
				end
				if (!emit) begin
					out_col_q <= ocol_e;
					out_row_q <= orow_e;
				end else if (ocol_inc >= 32'(w_eff)) begin
					out_col_q <= '0;
					out_row_q <= orow_inc;
				end else begin
					out_col_q <= CW'(ocol_inc);
					out_row_q <= orow_e;
				end
			end
		end
	end

	// Hold the accepted item for the read-modify-write cycle
	always_ff @(posedge clk) begin
		if (s_acc) begin
			item_col_q  <= col_e;
			item_pix_q  <= pix_in;
			item_feed_q <= feeding;
			item_row0_q <= (row_e == '0);
			item_col0_q <= (col_e == '0);
			item_emit_q <= emit;
			item_last_q <= last_phase;
			item_eor_q  <= eor;
			item_eof_q  <= eof;
		end
	end

	// Item sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc && !item_skip) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= item_emit_q ? ST_ROOT : ST_IDLE;
				end
				ST_ROOT: begin
					if (root_done) begin
						state_q <= out_free ? ST_IDLE : ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Build the new column; the first row replicates the pixel upward, drains replicate the middle row downward
	always_comb begin
		px_top = (item_feed_q && item_row0_q) ? item_pix_q
			: lb_rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
		px_mid = (item_feed_q && item_row0_q) ? item_pix_q
			: lb_rd_data[PIXEL_BITS-1:0];
		px_bot = item_feed_q ? item_pix_q : px_mid;

		lb_wr_en   = (state_q == ST_READ) && item_feed_q;
		lb_wr_data = {px_mid, item_pix_q};

		win_ctl.update     = (state_q == ST_READ) && !item_last_q;
		win_ctl.load       = item_col0_q;
		win_ctl.grad       = (state_q == ST_READ) && item_emit_q;
		win_ctl.center_sel = item_col0_q || item_last_q;
	end

	sobet_linebuf #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (CW),
		.DATA_W (2 * PIXEL_BITS)
	) u_linebuf (
		.clk     (clk),
		.rd_en   (s_acc),
		.rd_addr (col_e),
		.rd_data (lb_rd_data),
		.wr_en   (lb_wr_en),
		.wr_addr (item_col_q),
		.wr_data (lb_wr_data)
	);

	sobet_window #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (win_ctl),
		.col_top   (px_top),
		.col_mid   (px_mid),
		.col_bot   (px_bot),
		.sum_valid (sum_valid),
		.sum_sq    (sum_sq)
	);

	sobet_isqrt #(
		.ROOT_W (RW)
	) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sum_valid),
		.value  ((2 * RW)'(sum_sq)),
		.done   (root_done),
		.root   (root)
	);

	// Saturate and threshold the root
	always_comb begin
		mag_sat  = (32'(root) > 32'(sobet_pkg::MAG_MAX)) ? sobet_pkg::MAG_MAX : MAG_W'(root);
		edge_nx  = (mag_sat < edge_threshold_q) ? '0 : mag_sat;
		out_free = !m_tvalid_q || m_tready;
		load_out = out_free && (((state_q == ST_ROOT) && root_done) || (state_q == ST_OUT));
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			mag_q     <= mag_sat;
			edge_q    <= edge_nx;
			is_edge_q <= (edge_nx != '0);
			eor_q     <= item_eor_q;
			eof_q     <= item_eof_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, is_edge_q, edge_q, mag_q};
	assign m_tlast  = eor_q;
	assign m_tuser  = eof_q;

	`SOBET_CHECK_NEXT(a_item_starts, s_acc && !item_skip, state_q == ST_READ, "item not started")
	`SOBET_CHECK_NOW(a_sum_in_root, sum_valid, state_q == ST_ROOT, "gradient sum outside root wait")
	`SOBET_CHECK_NOW(a_done_in_root, root_done, state_q == ST_ROOT, "root result outside root wait")

endmodule

FILE: tb/sv/sobel_edge_threshold_test.sv
// Self-checking testbench for the streaming Sobel edge magnitude block.
`timescale 1ns / 1ps

module sobel_edge_threshold_test;
	import sobet_pkg::*;

	localparam int LINE_DEPTH = 1024;
	localparam int SETTLE = 32;          // cycles after the last result before a register write
	localparam int RANDOM_ITEMS = 950;
	localparam int TIMEOUT_NS = 5_000_000;
	localparam logic CMD_DRAIN = 1'b1;

	typedef enum int {TEX_NOISE, TEX_EXTREME, TEX_SMOOTH, TEX_FLAT} texture_t;

	typedef struct packed {
		logic [MAG_W-1:0] magnitude;
		logic [MAG_W-1:0] edge_value;
		logic             is_edge;
		logic             end_of_row;
		logic             end_of_frame;
	} edge_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [GREY_W-1:0]      s_tdata = '0;
	logic                   s_tuser = CMD_PIXEL;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   m_tlast;
	logic                   m_tuser;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_FRAME_WIDTH;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Mirror of the block: registers, line stores, window and raster counters
	logic [FW_W-1:0]   frame_width_reg = FRAME_WIDTH_RST;
	logic [FH_W-1:0]   frame_height_reg = FRAME_HEIGHT_RST;
	logic [THR_W-1:0]  threshold_reg = EDGE_THRESHOLD_RST;
	logic [GREY_W-1:0] upper_row [LINE_DEPTH];
	logic [GREY_W-1:0] middle_row [LINE_DEPTH];
	logic [GREY_W-1:0] win [9] = '{default: '0};
	int unsigned       in_col = 0;
	int unsigned       in_row = 0;
	int unsigned       out_col = 0;
	int unsigned       out_row = 0;

	edge_result_t expected_edges [$];

	bit feed_gaps = 1'b0;
	bit sink_stalls = 1'b0;
	int noise_pct = 0;
	int stall_left = 0;
	int fail_count = 0;
	int results_checked = 0;
	int items_taken = 0;
	int items_dropped = 0;
	int frames_done = 0;

	sobel_edge_threshold #(
		.MAX_WIDTH(LINE_DEPTH),
		.PIXEL_BITS(GREY_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void note_failure(string what);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] %s", $time, what);
		else if (fail_count == 11)
			$display("further failures are counted only");
	endfunction

	function automatic int unsigned eff_width();
		if (frame_width_reg == 0)
			return 1;
		if (frame_width_reg > LINE_DEPTH)
			return LINE_DEPTH;
		return frame_width_reg;
	endfunction

	function automatic int unsigned eff_height();
		return (frame_height_reg == 0) ? 1 : frame_height_reg;
	endfunction

	// Counters outside the current frame size mean the next item opens a new frame
	function automatic bit counters_stale();
		int unsigned w;
		int unsigned h;
		w = eff_width();
		h = eff_height();
		return in_col >= w || in_row > h + 1 || (in_row == h + 1 && in_col > 0);
	endfunction

	function automatic bit frame_open();
		if (counters_stale())
			return 1'b0;
		return in_row != 0 || in_col != 0;
	endfunction

	function automatic bit next_is_pixel();
		return counters_stale() || in_row < eff_height();
	endfunction

	// Sobel magnitude over the window; lc/cc/rc pick the left, center and right column
	function automatic int unsigned sobel_magnitude(int lc, int cc, int rc);
		int p [9];
		int gx;
		int gy;
		int unsigned sq;
		int unsigned root;
		int unsigned trial;
		int b;
		foreach (p[i])
			p[i] = win[i];
		gx = (p[lc*3] + 2 * p[lc*3+1] + p[lc*3+2]) - (p[rc*3] + 2 * p[rc*3+1] + p[rc*3+2]);
		gy = (p[lc*3] + 2 * p[cc*3] + p[rc*3]) - (p[lc*3+2] + 2 * p[cc*3+2] + p[rc*3+2]);
		sq = gx * gx + gy * gy;
		// floor square root, one bit at a time from the top
		root = 0;
		for (b = 10; b >= 0; b--) begin
			trial = root | (1 << b);
			if (trial * trial <= sq)
				root = trial;
		end
		return root;
	endfunction

	// Advance the mirror by one accepted item; returns 0 when the block drops it
	function automatic bit predict_edge_step(logic cmd, logic [GREY_W-1:0] grey);
		int unsigned w;
		int unsigned h;
		int unsigned col;
		int unsigned mag;
		logic [GREY_W-1:0] top;
		logic [GREY_W-1:0] mid;
		logic [GREY_W-1:0] bot;
		bit feeding;
		bit emit;
		bit last_phase;
		edge_result_t r;
		w = eff_width();
		h = eff_height();
		if (counters_stale()) begin
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
		end
		feeding = in_row < h;
		if (feeding != (cmd == CMD_PIXEL))
			return 1'b0;
		col = in_col;
		emit = in_row >= 2 || (in_row == 1 && col >= 1);
		last_phase = in_row == h + 1;
		mag = 0;
		if (!last_phase) begin
			// first row replicates itself upward, drains replicate the last row downward
			if (feeding && in_row == 0) begin
				top = grey;
				mid = grey;
			end else begin
				top = upper_row[col];
				mid = middle_row[col];
			end
			bot = feeding ? grey : mid;
			if (feeding) begin
				upper_row[col] = mid;
				middle_row[col] = grey;
			end
			if (col == 0) begin
				if (emit)
					mag = sobel_magnitude(1, 2, 2);
				for (int c = 0; c < 3; c++) begin
					win[c*3] = top;
					win[c*3+1] = mid;
					win[c*3+2] = bot;
				end
			end else begin
				for (int i = 0; i < 6; i++)
					win[i] = win[i+3];
				win[6] = top;
				win[7] = mid;
				win[8] = bot;
				if (emit)
					mag = sobel_magnitude(0, 1, 2);
			end
		end else if (emit) begin
			mag = sobel_magnitude(1, 2, 2);
		end
		if (emit) begin
			r.magnitude = mag;
			r.edge_value = (mag < threshold_reg) ? '0 : mag;
			r.is_edge = r.edge_value != 0;
			r.end_of_row = out_col + 1 >= w;
			r.end_of_frame = r.end_of_row && out_row + 1 >= h;
			expected_edges.push_back(r);
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
		if (last_phase) begin
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
		end else begin
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
		end
		return 1'b1;
	endfunction

	// Drive one transaction on the input stream, leaving tvalid high on return
	task automatic send_item(input logic cmd, input logic [GREY_W-1:0] grey);
		if (feed_gaps && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= grey;
		do
			@(posedge clk);
		while (!s_tready);
		if (predict_edge_step(cmd, grey))
			items_taken++;
		else
			items_dropped++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int unsigned value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value[CFG_DATA_W-1:0];
		case (index)
			REG_FRAME_WIDTH:    frame_width_reg = value[FW_W-1:0];
			REG_FRAME_HEIGHT:   frame_height_reg = value[FH_W-1:0];
			REG_EDGE_THRESHOLD: threshold_reg = value[THR_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Hold the input, wait for every expected result, then let the block settle
	task automatic wait_for_results(input int settle);
		int guard;
		s_tvalid <= 1'b0;
		guard = 0;
		while (expected_edges.size() != 0 && guard < 5000) begin
			@(negedge clk);
			guard++;
		end
		if (expected_edges.size() != 0) begin
			note_failure($sformatf("%0d expected results never arrived", expected_edges.size()));
			expected_edges.delete();
		end
		repeat (settle) @(negedge clk);
	endtask

	// Feed pixels then drains until the frame closes, or stop after stop_after items
	task automatic run_frame(input int stop_after, input texture_t texture);
		int sent;
		logic [GREY_W-1:0] level;
		logic [GREY_W-1:0] grey;
		sent = 0;
		level = 8'($urandom);
		do begin
			if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct)
				send_item(next_is_pixel() ? CMD_DRAIN : CMD_PIXEL, 8'($urandom));
			if (next_is_pixel()) begin
				case (texture)
					TEX_EXTREME: grey = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					TEX_SMOOTH: begin
						level = level + 8'($urandom_range(0, 6)) - 8'd3;
						grey = level;
					end
					TEX_FLAT: grey = level;
					default: grey = 8'($urandom);
				endcase
				send_item(CMD_PIXEL, grey);
			end else begin
				send_item(CMD_DRAIN, 8'($urandom));
			end
			sent++;
		end while (frame_open() && !(stop_after != 0 && sent >= stop_after));
		if (!frame_open())
			frames_done++;
	endtask

	// Short frames: reset threshold, early drain, late pixel, one-row and zero sizes
	task automatic test_directed();
		write_reg(REG_FRAME_WIDTH, 3);
		write_reg(REG_FRAME_HEIGHT, 2);
		send_item(CMD_PIXEL, 8'hFF);
		send_item(CMD_PIXEL, 8'h00);
		send_item(CMD_DRAIN, 8'hA5);
		send_item(CMD_PIXEL, 8'hFF);
		send_item(CMD_PIXEL, 8'h00);
		send_item(CMD_PIXEL, 8'hFF);
		send_item(CMD_PIXEL, 8'h00);
		send_item(CMD_DRAIN, 8'h00);
		send_item(CMD_PIXEL, 8'h5A);
		repeat (3) send_item(CMD_DRAIN, 8'hFF);
		wait_for_results(SETTLE);
		// one row: the first drain gives no result
		write_reg(REG_FRAME_WIDTH, 2);
		write_reg(REG_FRAME_HEIGHT, 1);
		send_item(CMD_PIXEL, 8'h80);
		send_item(CMD_PIXEL, 8'h7F);
		repeat (3) send_item(CMD_DRAIN, 8'h00);
		wait_for_results(SETTLE);
		// zero width and height act as a single pixel
		write_reg(REG_FRAME_WIDTH, 0);
		write_reg(REG_FRAME_HEIGHT, 0);
		send_item(CMD_PIXEL, 8'h33);
		repeat (2) send_item(CMD_DRAIN, 8'hCC);
		wait_for_results(SETTLE);
	endtask

	task automatic test_threshold_extremes();
		int unsigned limits [4] = '{0, 2047, 1, 1443};
		write_reg(REG_FRAME_WIDTH, 4);
		write_reg(REG_FRAME_HEIGHT, 3);
		foreach (limits[i]) begin
			write_reg(REG_EDGE_THRESHOLD, limits[i]);
			run_frame(0, TEX_EXTREME);
			wait_for_results(SETTLE);
		end
	endtask

	// Resize between transactions of an open frame
	task automatic test_size_change();
		feed_gaps = 1'b1;
		sink_stalls = 1'b1;
		write_reg(REG_EDGE_THRESHOLD, 64);
		// narrow below the current column: the frame restarts
		write_reg(REG_FRAME_WIDTH, 4);
		write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
		run_frame(14, TEX_NOISE);
		wait_for_results(SETTLE);
		write_reg(REG_FRAME_WIDTH, 2);
		write_reg(REG_FRAME_HEIGHT, 3);
		run_frame(0, TEX_NOISE);
		wait_for_results(SETTLE);
		// lower the height below the current row: the frame restarts
		write_reg(REG_FRAME_WIDTH, 3);
		write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
		run_frame(13, TEX_EXTREME);
		wait_for_results(SETTLE);
		write_reg(REG_FRAME_HEIGHT, 2);
		run_frame(0, TEX_EXTREME);
		wait_for_results(SETTLE);
		// lower the height onto the current row: drains become due
		write_reg(REG_FRAME_HEIGHT, 16'hFFFF);
		run_frame(8, TEX_NOISE);
		wait_for_results(SETTLE);
		write_reg(REG_FRAME_HEIGHT, 2);
		run_frame(0, TEX_NOISE);
		wait_for_results(SETTLE);
		// narrow but stay inside the row: the frame goes on
		write_reg(REG_FRAME_WIDTH, 5);
		write_reg(REG_FRAME_HEIGHT, 4);
		run_frame(7, TEX_SMOOTH);
		wait_for_results(SETTLE);
		write_reg(REG_FRAME_WIDTH, 3);
		run_frame(0, TEX_SMOOTH);
		wait_for_results(SETTLE);
	endtask

	// Width above the line store depth clamps to a full-width row
	task automatic test_wide_row();
		write_reg(REG_FRAME_WIDTH, 2047);
		write_reg(REG_FRAME_HEIGHT, 1);
		write_reg(REG_EDGE_THRESHOLD, 200);
		run_frame(0, TEX_NOISE);
		wait_for_results(SETTLE);
	endtask

	task automatic test_random_frames();
		int first_item;
		int unsigned w;
		int unsigned h;
		bit quiet;
		texture_t texture;
		first_item = items_taken;
		while (items_taken - first_item < RANDOM_ITEMS) begin
			// the last part of the run keeps both streams busy
			quiet = items_taken - first_item >= RANDOM_ITEMS * 4 / 5;
			feed_gaps = !quiet && $urandom_range(0, 2) != 0;
			sink_stalls = !quiet && $urandom_range(0, 2) != 0;
			noise_pct = (!quiet && $urandom_range(0, 3) == 0) ? 10 : 0;
			texture = texture_t'($urandom_range(0, 3));
			case ($urandom_range(0, 9))
				0: w = 1;
				1: w = 2;
				9: w = $urandom_range(13, 40);
				default: w = $urandom_range(3, 12);
			endcase
			h = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
			write_reg(REG_FRAME_WIDTH, w);
			write_reg(REG_FRAME_HEIGHT, h);
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_EDGE_THRESHOLD, $urandom_range(0, 3) == 0 ?
					$urandom_range(0, 2047) : $urandom_range(0, 400));
			// broken frame: stop partway, shrink or keep the width, then finish
			if (!quiet && $urandom_range(0, 9) == 0) begin
				run_frame((w * h > 1) ? $urandom_range(1, w * h - 1) : 1, texture);
				wait_for_results(SETTLE);
				write_reg(REG_FRAME_WIDTH, $urandom_range(1, w));
				write_reg(REG_FRAME_HEIGHT, $urandom_range(1, 6));
			end
			run_frame(0, texture);
			wait_for_results(SETTLE);
		end
	endtask

	// Result sink with bursts of backpressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin : check_results
		edge_result_t got;
		edge_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.magnitude = m_tdata[MAG_W-1:0];
			got.edge_value = m_tdata[2*MAG_W-1:MAG_W];
			got.is_edge = m_tdata[2*MAG_W];
			got.end_of_row = m_tlast;
			got.end_of_frame = m_tuser;
			if (expected_edges.size() == 0) begin
				note_failure($sformatf("unexpected result: mag %0d edge %0d",
					got.magnitude, got.edge_value));
			end else begin
				want = expected_edges.pop_front();
				results_checked++;
				if (got != want)
					note_failure($sformatf({"result %0d: expected mag %0d edge %0d is_edge %b ",
						"eor %b eof %b, got mag %0d edge %0d is_edge %b eor %b eof %b"},
						results_checked, want.magnitude, want.edge_value, want.is_edge,
						want.end_of_row, want.end_of_frame, got.magnitude, got.edge_value,
						got.is_edge, got.end_of_row, got.end_of_frame));
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("sobel_edge_threshold_test: FAIL");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_threshold_extremes();
		test_size_change();
		test_wide_row();
		test_random_frames();
		wait_for_results(SETTLE);
		$display("checked %0d results from %0d taken and %0d dropped transactions, %0d frames",
			results_checked, items_taken, items_dropped, frames_done);
		$display("sizes 1x1 to 1024 wide and 65535 tall, thresholds 0 to 2047, %0d failures",
			fail_count);
		if (fail_count == 0)
			$display("sobel_edge_threshold_test: PASS");
		else
			$display("sobel_edge_threshold_test: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/sobet_pkg.sv
rtl/sobet_linebuf.sv
rtl/sobet_window.sv
rtl/sobet_isqrt.sv
rtl/sobel_edge_threshold.sv
tb/sv/sobel_edge_threshold_test.sv
